>>> hw/rtl/tcs_pkg.sv
// Shared types and fixed constants of the text console scroller.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package tcs_pkg;

    // Operation codes of an input item.
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [7:0]  NEWLINE_CHAR = 8'd10;
    localparam logic [7:0]  BLANK_CHAR   = 8'h20;
    localparam logic [15:0] RESET_CELL   = 16'h0F20;
    localparam logic [15:0] ATTR_MASK    = 16'hFF00;
    localparam logic [7:0]  RESET_FILL   = 8'h0F;

    typedef struct packed {
        logic        op;
        logic [7:0]  char_code;
        logic [10:0] cell_address;
    } in_item_t;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
    } out_item_t;

    // Commands from the sequencer to the cursor tracker.
    typedef struct packed {
        logic char_step;
        logic line_step;
    } cursor_cmd_t;

    // Cursor status seen by the sequencer.
    typedef struct packed {
        logic line_end;
        logic bottom_row;
    } cursor_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/tcs_cursor.sv
// Cursor tracker: column, row and the linear cell address of the cursor.
// Depends on tcs_pkg for the command and status structs.
`default_nettype none

module tcs_cursor #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  tcs_pkg::cursor_cmd_t                    cmd,
    output tcs_pkg::cursor_stat_t                   stat,
    output logic [$clog2(COLUMNS)-1:0]              column,
    output logic [$clog2(ROWS)-1:0]                 row,
    output logic [$clog2(ROWS*COLUMNS)-1:0]         addr
);
    import tcs_pkg::*;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(ROWS * COLUMNS);

    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] ROW_PITCH = ADDR_W'(COLUMNS);

    logic [COL_W-1:0]  col_reg,  col_next;
    logic [ROW_W-1:0]  row_reg,  row_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic              new_line;

    assign stat.line_end   = (col_reg == COL_LAST);
    assign stat.bottom_row = (row_reg == ROW_LAST);

    // A newline, or a character written into the last column, starts a new row.
    assign new_line = cmd.line_step || (cmd.char_step && stat.line_end);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        base_next = base_reg;
        if (new_line)
        begin
            col_next = '0;
            // On the last row the screen scrolls and the cursor stays on that row.
            if (!stat.bottom_row)
            begin
                row_next  = row_reg + 1'b1;
                base_next = base_reg + ROW_PITCH;
            end
        end
        else if (cmd.char_step)
        begin
            col_next = col_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
        end
    end

    assign column = col_reg;
    assign row    = row_reg;
    assign addr   = base_reg + ADDR_W'(col_reg);

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < COLUMNS)
        else $error("cursor column beyond the last column");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(row_reg) < ROWS)
        else $error("cursor row beyond the last row");

    a_base_track: assert property (@(posedge clk) disable iff (!rst_n)
        base_reg == ADDR_W'(32'(row_reg) * 32'(COLUMNS)))
        else $error("row base address lost track of the row");

endmodule

`default_nettype wire

>>> hw/rtl/text_console_scroller_core.sv
// Top level of the text console scroller: sequencer and cell memory.
// Depends on tcs_pkg and instantiates tcs_cursor.
`default_nettype none

// A character-cell console of ROWS by COLUMNS cells, each 16 bits with the
// attribute in the high byte and the character in the low byte. An item is
// taken when start is high and busy is low. Every item gives exactly one
// result, shown on result for a single cycle with done high; the receiver
// cannot stall it, so it must take every transfer as it comes. A newline that
// does not scroll answers in the cycle after it is taken. A read and a put
// each answer after a registered read of the cell memory; a put reads the
// cell and then writes it back with its attribute kept. When a newline or a
// wrap leaves the bottom row, the screen scrolls: every cell is moved up one
// row through the single read and single write port of the cell memory, one
// cell per cycle, and the bottom row is filled with blanks in the fill
// attribute. A scrolling newline answers when the scroll ends, and a put that
// wraps first writes its cell and then scrolls. After reset the block clears
// the memory to blanks with attribute 0x0F, one cell per cycle, and holds
// busy high until every cell is cleared.
// The fill attribute is written over the cfg channel, which is always ready;
// write it only while no item is in progress. The cursor fields of a result
// give the cursor after the item.
module text_console_scroller_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    input  tcs_pkg::in_item_t    item,
    output logic                 done,
    output tcs_pkg::out_item_t   result,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire  [7:0]           cfg_data
);
    import tcs_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int SCAN_W = $clog2(CELLS + 1);

    // Last cell of the clearing pass, number of cells moved by a scroll,
    // and the final step of a scroll, where the last blank is written.
    localparam logic [SCAN_W-1:0] SCAN_CLR_LAST = SCAN_W'(CELLS - 1);
    localparam logic [SCAN_W-1:0] SCAN_COPY_END = SCAN_W'(CELLS - COLUMNS);
    localparam logic [SCAN_W-1:0] SCAN_END      = SCAN_W'(CELLS);
    localparam logic [SCAN_W-1:0] SCAN_PITCH    = SCAN_W'(COLUMNS);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_PUT    = 3'd3;
    localparam logic [2:0] S_SCROLL = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [SCAN_W-1:0] scan_reg,  scan_next;
    logic [7:0]        fill_reg;
    logic              done_reg,  done_next;
    logic [15:0]       value_reg, value_next;
    logic [7:0]        char_reg;
    logic              range_reg;

    // Cell memory: one write port and one registered read port.
    logic [15:0]       cell_mem [CELLS];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [15:0]       mem_rdata_reg;

    cursor_cmd_t       cur_cmd;
    cursor_stat_t      cur_stat;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [ADDR_W-1:0] cur_addr;

    logic              accept;
    logic              in_range;
    logic [31:0]       col_wide;
    logic [31:0]       row_wide;

    tcs_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cur_cmd),
        .stat   (cur_stat),
        .column (cur_col),
        .row    (cur_row),
        .addr   (cur_addr)
    );

    assign accept   = start && (state_reg == S_IDLE);
    assign in_range = (32'(item.cell_address) < 32'(CELLS));

    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        done_next  = 1'b0;
        value_next = value_reg;
        mem_we     = 1'b0;
        mem_waddr  = ADDR_W'(scan_reg);
        mem_wdata  = RESET_CELL;
        mem_re     = 1'b0;
        mem_raddr  = cur_addr;
        cur_cmd    = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (scan_reg == SCAN_CLR_LAST)
                begin
                    state_next = S_IDLE;
                    scan_next  = '0;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.op == OP_READ)
                    begin
                        mem_re     = in_range;
                        mem_raddr  = ADDR_W'(item.cell_address);
                        state_next = S_READ;
                    end
                    else if (item.char_code == NEWLINE_CHAR)
                    begin
                        cur_cmd.line_step = 1'b1;
                        value_next        = '0;
                        if (cur_stat.bottom_row)
                        begin
                            state_next = S_SCROLL;
                            scan_next  = '0;
                        end
                        else
                        begin
                            done_next = 1'b1;
                        end
                    end
                    else
                    begin
                        // Fetch the cell under the cursor to keep its attribute.
                        mem_re     = 1'b1;
                        mem_raddr  = cur_addr;
                        state_next = S_PUT;
                    end
                end
            end

            S_READ:
            begin
                value_next = range_reg ? mem_rdata_reg : 16'h0000;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_PUT:
            begin
                mem_we            = 1'b1;
                mem_waddr         = cur_addr;
                mem_wdata         = (mem_rdata_reg & ATTR_MASK) | {8'h00, char_reg};
                cur_cmd.char_step = 1'b1;
                value_next        = '0;
                if (cur_stat.line_end && cur_stat.bottom_row)
                begin
                    state_next = S_SCROLL;
                    scan_next  = '0;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_SCROLL:
            begin
                // Step k reads the cell one row below cell k and writes cell
                // k-1 with the data read in the step before, or with a blank
                // once the bottom row is reached.
                mem_re    = (scan_reg < SCAN_COPY_END);
                mem_raddr = ADDR_W'(scan_reg + SCAN_PITCH);
                mem_we    = (scan_reg != '0);
                mem_waddr = ADDR_W'(scan_reg - 1'b1);
                mem_wdata = (scan_reg <= SCAN_COPY_END) ? mem_rdata_reg
                                                        : {fill_reg, BLANK_CHAR};
                if (scan_reg == SCAN_END)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    scan_next  = '0;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            scan_reg  <= '0;
            done_reg  <= 1'b0;
            fill_reg  <= RESET_FILL;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                fill_reg <= cfg_data;
            end
        end
    end

    // Payload registers of the current item and the result value.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        if (accept)
        begin
            char_reg  <= item.char_code;
            range_reg <= in_range;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= cell_mem[mem_raddr];
        end
    end

    // The cursor cannot move before the next item is taken, which is no
    // earlier than the cycle in which the result is shown, so the live
    // cursor is the cursor after the item.
    assign col_wide = 32'(cur_col);
    assign row_wide = 32'(cur_row);

    assign busy                 = (state_reg != S_IDLE);
    assign cfg_ready            = 1'b1;
    assign done                 = done_reg;
    assign result.cell_value    = value_reg;
    assign result.cursor_column = col_wide[6:0];
    assign result.cursor_row    = row_wide[4:0];

    a_no_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !mem_we)
        else $error("memory write while a new item is taken");

    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (32'(mem_waddr) < 32'(CELLS)))
        else $error("memory write beyond the last cell");

    a_scroll_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCROLL && scan_reg == SCAN_END) |=> (done && !busy))
        else $error("scroll finished without a result");

    a_no_done_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |=> !done)
        else $error("result during the clearing pass");

    a_put_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUT) |-> (mem_we && mem_waddr == cur_addr))
        else $error("put did not write the cell under the cursor");

endmodule

`default_nettype wire
